// File: rtl/core/dpc_pkg.sv
`default_nettype none
package dpc_pkg;

   localparam int DATA_W         = 32;
   localparam int PERIOD_W       = 31;
   localparam int FRAC_BITS      = 16;
   localparam int USE_DERIVATIVE = 1;
   localparam int CSR_ADDR_W     = 4;
   localparam int OPND_W         = DATA_W + 1;
   localparam int PROD_W         = 2 * OPND_W;
   localparam int SUM_W          = DATA_W + 2;
   localparam int CH_W           = 1;
   localparam int PH_W           = 3;
   localparam int STEP_W         = CH_W + PH_W;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [PERIOD_W-1:0]      period_type;
   typedef logic signed [OPND_W-1:0] opnd_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic [CSR_ADDR_W-1:0]    addr_type;
   typedef logic [PH_W-1:0]          phase_type;
   typedef logic [STEP_W-1:0]        step_type;

   localparam data_type DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam data_type DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Register indexes of the configuration port.
   localparam addr_type REG_TARGET     = CSR_ADDR_W'(0);
   localparam addr_type REG_GAIN_P     = CSR_ADDR_W'(1);
   localparam addr_type REG_GAIN_I     = CSR_ADDR_W'(2);
   localparam addr_type REG_GAIN_D     = CSR_ADDR_W'(3);
   localparam addr_type REG_HALF_PER   = CSR_ADDR_W'(4);
   localparam addr_type REG_INV_PER    = CSR_ADDR_W'(5);
   localparam addr_type REG_OUT_MIN    = CSR_ADDR_W'(6);
   localparam addr_type REG_OUT_MAX    = CSR_ADDR_W'(7);

   localparam data_type   TARGET_RST   = DATA_W'(0);
   localparam data_type   GAIN_P_RST   = DATA_W'(65536);
   localparam data_type   GAIN_I_RST   = DATA_W'(0);
   localparam data_type   GAIN_D_RST   = DATA_W'(0);
   localparam period_type HALF_PER_RST = PERIOD_W'(32768);
   localparam period_type INV_PER_RST  = PERIOD_W'(65536);
   localparam data_type   OUT_MIN_RST  = DATA_W'(0);
   localparam data_type   OUT_MAX_RST  = DATA_W'(6553600);

   // Phases of the per-channel sequence.
   localparam phase_type PH_ERROR = PH_W'(0);
   localparam phase_type PH_MUL_P = PH_W'(1);
   localparam phase_type PH_MUL_T = PH_W'(2);
   localparam phase_type PH_MUL_V = PH_W'(3);
   localparam phase_type PH_MUL_I = PH_W'(4);
   localparam phase_type PH_MUL_D = PH_W'(5);
   localparam phase_type PH_WB_D  = PH_W'(6);
   localparam phase_type PH_SUM   = PH_W'(7);

   localparam step_type STEP_LAST = {STEP_W{1'b1}};

   typedef struct packed {
      data_type   target_value;
      data_type   gain_p;
      data_type   gain_i;
      data_type   gain_d;
      period_type half_period;
      period_type inverse_period;
      data_type   out_min;
      data_type   out_max;
   } cfg_type;

   typedef struct packed {
      logic     load_in;
      logic     run;
      step_type step;
      logic     load_out;
   } cmd_type;

   function automatic data_type sat_sum(input sum_type v);
      logic [SUM_W-DATA_W:0] upper;
      upper = v[SUM_W-1:DATA_W-1];
      if ((&upper) || !(|upper)) begin
         return v[DATA_W-1:0];
      end else if (v[SUM_W-1]) begin
         return DATA_MIN;
      end else begin
         return DATA_MAX;
      end
   endfunction

   // Fixed-point product: arithmetic shift right, then saturation to 32 bits.
   function automatic data_type fix_mul(input prod_type p);
      prod_type              s;
      logic [PROD_W-DATA_W:0] upper;
      s = p >>> FRAC_BITS;
      upper = s[PROD_W-1:DATA_W-1];
      if ((&upper) || !(|upper)) begin
         return s[DATA_W-1:0];
      end else if (s[PROD_W-1]) begin
         return DATA_MIN;
      end else begin
         return DATA_MAX;
      end
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/dpc_if.sv
`default_nettype none
interface dpc_req_if;
   logic               valid;
   logic               ready;
   dpc_pkg::data_type  measured_a;
   dpc_pkg::data_type  measured_b;
   modport source (output valid, output measured_a, output measured_b, input ready);
   modport sink (input valid, input measured_a, input measured_b, output ready);
endinterface

interface dpc_rsp_if;
   logic               valid;
   logic               ready;
   dpc_pkg::data_type  drive_a;
   dpc_pkg::data_type  drive_b;
   modport source (output valid, output drive_a, output drive_b, input ready);
   modport sink (input valid, input drive_a, input drive_b, output ready);
endinterface

interface dpc_csr_if;
   logic                         valid;
   logic                         ready;
   dpc_pkg::addr_type            index;
   logic [dpc_pkg::DATA_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/dpc_csr.sv
`default_nettype none
module dpc_csr (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        wr_valid,
   output logic                       wr_ready,
   input  wire dpc_pkg::addr_type     wr_index,
   input  wire [dpc_pkg::DATA_W-1:0]  wr_data,
   output dpc_pkg::cfg_type           cfg
);

   dpc_pkg::cfg_type cfg_ff;
   dpc_pkg::cfg_type cfg_in;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (wr_index)
            dpc_pkg::REG_TARGET:   cfg_in.target_value   = wr_data;
            dpc_pkg::REG_GAIN_P:   cfg_in.gain_p         = wr_data;
            dpc_pkg::REG_GAIN_I:   cfg_in.gain_i         = wr_data;
            dpc_pkg::REG_GAIN_D:   cfg_in.gain_d         = wr_data;
            dpc_pkg::REG_HALF_PER: cfg_in.half_period    = wr_data[dpc_pkg::PERIOD_W-1:0];
            dpc_pkg::REG_INV_PER:  cfg_in.inverse_period = wr_data[dpc_pkg::PERIOD_W-1:0];
            dpc_pkg::REG_OUT_MIN:  cfg_in.out_min        = wr_data;
            dpc_pkg::REG_OUT_MAX:  cfg_in.out_max        = wr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_value   <= dpc_pkg::TARGET_RST;
         cfg_ff.gain_p         <= dpc_pkg::GAIN_P_RST;
         cfg_ff.gain_i         <= dpc_pkg::GAIN_I_RST;
         cfg_ff.gain_d         <= dpc_pkg::GAIN_D_RST;
         cfg_ff.half_period    <= dpc_pkg::HALF_PER_RST;
         cfg_ff.inverse_period <= dpc_pkg::INV_PER_RST;
         cfg_ff.out_min        <= dpc_pkg::OUT_MIN_RST;
         cfg_ff.out_max        <= dpc_pkg::OUT_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/dpc_ctrl.sv
`default_nettype none
module dpc_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output dpc_pkg::cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]        state_ff, state_in;
   dpc_pkg::step_type step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd.load_in  = 1'b0;
      cmd.run      = 1'b0;
      cmd.step     = step_ff;
      cmd.load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               step_in     = '0;
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.run = 1'b1;
            step_in = step_ff + dpc_pkg::STEP_W'(1);
            if (step_ff == dpc_pkg::STEP_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // The result register is reused once the previous result has gone.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_out | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/dpc_datapath.sv
`default_nettype none
module dpc_datapath (
   input  wire                      clock,
   input  wire                      reset,
   input  wire dpc_pkg::cfg_type    cfg,
   input  wire dpc_pkg::cmd_type    cmd,
   input  wire dpc_pkg::data_type   measured_a,
   input  wire dpc_pkg::data_type   measured_b,
   output dpc_pkg::data_type        drive_a,
   output dpc_pkg::data_type        drive_b
);

   dpc_pkg::data_type  meas_ff   [2];
   dpc_pkg::data_type  integ_ff  [2];
   dpc_pkg::data_type  prev_ff   [2];
   dpc_pkg::data_type  work_ff   [2];
   dpc_pkg::data_type  err_ff;
   dpc_pkg::data_type  p_ff;
   dpc_pkg::data_type  i_ff;
   dpc_pkg::data_type  d_ff;
   dpc_pkg::data_type  dd_ff;
   dpc_pkg::prod_type  prod_ff;
   dpc_pkg::prod_type  prod_in;
   dpc_pkg::data_type  drive_a_ff;
   dpc_pkg::data_type  drive_b_ff;

   dpc_pkg::opnd_type  opnd_a;
   dpc_pkg::opnd_type  opnd_b;
   dpc_pkg::data_type  fix_out;
   dpc_pkg::data_type  sum_sat;
   dpc_pkg::data_type  clamped;
   dpc_pkg::phase_type phase;
   logic               ch;

   assign phase   = cmd.step[dpc_pkg::PH_W-1:0];
   assign ch      = cmd.step[dpc_pkg::STEP_W-1];
   assign drive_a = drive_a_ff;
   assign drive_b = drive_b_ff;
   assign fix_out = dpc_pkg::fix_mul(prod_ff);

   // Operand selection for the one shared multiplier.
   always_comb begin
      opnd_a = '0;
      opnd_b = '0;
      case (phase)
         dpc_pkg::PH_MUL_P: begin
            opnd_a = dpc_pkg::opnd_type'(cfg.gain_p);
            opnd_b = dpc_pkg::opnd_type'(err_ff);
         end
         dpc_pkg::PH_MUL_T: begin
            opnd_a = dpc_pkg::opnd_type'(err_ff) + dpc_pkg::opnd_type'(prev_ff[ch]);
            opnd_b = $signed({2'b00, cfg.half_period});
         end
         dpc_pkg::PH_MUL_V: begin
            opnd_a = dpc_pkg::opnd_type'(err_ff) - dpc_pkg::opnd_type'(prev_ff[ch]);
            opnd_b = $signed({2'b00, cfg.inverse_period});
         end
         dpc_pkg::PH_MUL_I: begin
            opnd_a = dpc_pkg::opnd_type'(cfg.gain_i);
            opnd_b = dpc_pkg::opnd_type'(integ_ff[ch]);
         end
         dpc_pkg::PH_MUL_D: begin
            opnd_a = dpc_pkg::opnd_type'(cfg.gain_d);
            opnd_b = dpc_pkg::opnd_type'(dd_ff);
         end
         default: begin
            opnd_a = '0;
            opnd_b = '0;
         end
      endcase
      prod_in = opnd_a * opnd_b;
   end

   always_comb begin
      sum_sat = dpc_pkg::sat_sum(dpc_pkg::sum_type'(p_ff) + dpc_pkg::sum_type'(i_ff)
                                 + dpc_pkg::sum_type'(d_ff));
      // With crossed limits the lower bound takes precedence.
      if (sum_sat < cfg.out_min) begin
         clamped = cfg.out_min;
      end else if (sum_sat > cfg.out_max) begin
         clamped = cfg.out_max;
      end else begin
         clamped = sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff[0] <= '0;
         integ_ff[1] <= '0;
         prev_ff[0]  <= '0;
         prev_ff[1]  <= '0;
      end else if (cmd.run) begin
         case (phase)
            dpc_pkg::PH_MUL_V: begin
               integ_ff[ch] <= dpc_pkg::sat_sum(dpc_pkg::sum_type'(integ_ff[ch])
                                                + dpc_pkg::sum_type'(fix_out));
            end
            dpc_pkg::PH_WB_D: begin
               prev_ff[ch] <= err_ff;
            end
            default: begin
               prev_ff[ch] <= prev_ff[ch];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         meas_ff[0] <= measured_a;
         meas_ff[1] <= measured_b;
      end
      if (cmd.load_out) begin
         drive_a_ff <= work_ff[0];
         drive_b_ff <= work_ff[1];
      end
      if (cmd.run) begin
         prod_ff <= prod_in;
         case (phase)
            dpc_pkg::PH_ERROR: begin
               err_ff <= dpc_pkg::sat_sum(dpc_pkg::sum_type'(cfg.target_value)
                                          - dpc_pkg::sum_type'(meas_ff[ch]));
            end
            dpc_pkg::PH_MUL_T: p_ff  <= fix_out;
            dpc_pkg::PH_MUL_I: dd_ff <= fix_out;
            dpc_pkg::PH_MUL_D: i_ff  <= fix_out;
            dpc_pkg::PH_WB_D: begin
               d_ff <= (dpc_pkg::USE_DERIVATIVE != 0) ? fix_out : dpc_pkg::data_type'(0);
            end
            dpc_pkg::PH_SUM: work_ff[ch] <= clamped;
            default: begin
               err_ff <= err_ff;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/dual_pid_controller_clamped_core.sv
`default_nettype none
// Two independent PID loops in signed Q16.16 sharing one setpoint: each request carries
// two measurements and yields one result with two clamped drive values. A result is
// offered once sixteen sequencer steps (eight per channel, five products each through a
// single shared 33 by 33 bit multiplier with a registered product) have run and a finish
// state has moved the result into the output register. The sequencer is then free again,
// so a request is taken only after the previous one is through, and later when the
// previous result is still waiting in the output register at the end of the sequence. A
// new request is accepted as soon as the sequencer is free, while the previous result may
// still wait in the output register. Configuration writes are taken in any cycle but must
// only be issued while no request is in flight.
module dual_pid_controller_clamped_core (
   input  wire        clock,
   input  wire        reset,
   dpc_req_if.sink    req_bus,
   dpc_rsp_if.source  rsp_bus,
   dpc_csr_if.sink    csr_bus
);

   dpc_pkg::cfg_type cfg;
   dpc_pkg::cmd_type cmd;

   dpc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_bus.valid),
      .wr_ready (csr_bus.ready),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.data),
      .cfg      (cfg)
   );

   dpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   dpc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .measured_a (req_bus.measured_a),
      .measured_b (req_bus.measured_b),
      .drive_a    (rsp_bus.drive_a),
      .drive_b    (rsp_bus.drive_b)
   );

endmodule
`default_nettype wire

// File: tb/sv/dual_pid_controller_clamped_core_tb.sv
module dual_pid_controller_clamped_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dpc_pkg::*;

   localparam int IDLE_MAX       = 14;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 104;

   localparam addr_type ADDR_TOP = '1;

   typedef struct {
      data_type a;
      data_type b;
   } chan_pair_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dpc_req_if req_bus ();
   dpc_rsp_if rsp_bus ();
   dpc_csr_if csr_bus ();

   dual_pid_controller_clamped_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Controller settings and loop state as the block should hold them.
   data_type   set_point, kp, ki, kd, lim_lo, lim_hi;
   period_type half_per, inv_per;
   longint     err_hist [2];
   longint     accum [2];

   chan_pair_t pending_meas [$];
   chan_pair_t expected_drives [$];

   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   bit   no_idle = 1'b0;
   bit   start_long_hold = 1'b0;
   bit   rsp_blocked = 1'b0;
   int   gap_left = 0;
   int   stall_left = 0;
   int   idle_cycles = 0;
   int   error_count = 0;

   function automatic longint sat32(input longint v);
      if (v > longint'(DATA_MAX)) return longint'(DATA_MAX);
      if (v < longint'(DATA_MIN)) return longint'(DATA_MIN);
      return v;
   endfunction

   function automatic longint qmul(input longint x, input longint y);
      return sat32((x * y) >>> FRAC_BITS);
   endfunction

   // One loop of the controller; updates that channel's integral and last error.
   function automatic data_type pid_drive(input int ch, input data_type meas);
      longint err, prop, intg, deriv, total;
      err = sat32(longint'(set_point) - longint'(meas));
      prop = qmul(longint'(kp), err);
      accum[ch] = sat32(accum[ch] + qmul(err + err_hist[ch], longint'(half_per)));
      intg = qmul(longint'(ki), accum[ch]);
      deriv = 0;
      if (USE_DERIVATIVE != 0) begin
         deriv = qmul(longint'(kd), qmul(err - err_hist[ch], longint'(inv_per)));
      end
      err_hist[ch] = err;
      total = sat32(prop + intg + deriv);
      // With crossed limits the lower bound takes precedence.
      if (total < longint'(lim_lo)) return lim_lo;
      if (total > longint'(lim_hi)) return lim_hi;
      return data_type'(total);
   endfunction

   function automatic int gap_draw();
      if (no_idle || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, IDLE_MAX);
   endfunction

   // Request driver.
   always @(negedge clock) begin
      chan_pair_t nxt;
      if (req_taken) gap_left = gap_draw();
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_meas.size() > 0) begin
            nxt = pending_meas.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.measured_a <= nxt.a;
            req_bus.measured_b <= nxt.b;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result receiver.
   always @(negedge clock) begin
      if (rsp_taken) stall_left = gap_draw();
      if (reset || rsp_blocked) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Long receiver hold-off so that the block backs up and stalls its input.
   initial begin
      wait (start_long_hold);
      rsp_blocked = 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      rsp_blocked = 1'b0;
   end

   // Sampling of all three channels, prediction and checking.
   always @(posedge clock) begin
      chan_pair_t want, got;
      logic       any_taken;
      any_taken = 1'b0;
      req_taken <= req_bus.valid && req_bus.ready;
      rsp_taken <= rsp_bus.valid && rsp_bus.ready;

      if (csr_bus.valid && csr_bus.ready) begin
         any_taken = 1'b1;
         case (csr_bus.index)
            REG_TARGET:   set_point = csr_bus.data;
            REG_GAIN_P:   kp        = csr_bus.data;
            REG_GAIN_I:   ki        = csr_bus.data;
            REG_GAIN_D:   kd        = csr_bus.data;
            REG_HALF_PER: half_per  = csr_bus.data[PERIOD_W-1:0];
            REG_INV_PER:  inv_per   = csr_bus.data[PERIOD_W-1:0];
            REG_OUT_MIN:  lim_lo    = csr_bus.data;
            REG_OUT_MAX:  lim_hi    = csr_bus.data;
            default: ;
         endcase
      end

      if (req_bus.valid && req_bus.ready) begin
         any_taken = 1'b1;
         got.a = pid_drive(0, req_bus.measured_a);
         got.b = pid_drive(1, req_bus.measured_b);
         expected_drives.push_back(got);
      end

      if (rsp_bus.valid && rsp_bus.ready) begin
         any_taken = 1'b1;
         if (expected_drives.size() == 0) begin
            $error("result with no request outstanding: drive_a %0d, drive_b %0d",
                   rsp_bus.drive_a, rsp_bus.drive_b);
            error_count++;
         end else begin
            want = expected_drives.pop_front();
            if (rsp_bus.drive_a !== want.a) begin
               $error("drive_a: expected %0d, actual %0d", want.a, rsp_bus.drive_a);
               error_count++;
            end
            if (rsp_bus.drive_b !== want.b) begin
               $error("drive_b: expected %0d, actual %0d", want.b, rsp_bus.drive_b);
               error_count++;
            end
         end
      end

      idle_cycles <= any_taken ? 0 : idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("FAIL dual_pid_controller_clamped_core");
      $finish;
   end

   task automatic queue_item(input data_type a, input data_type b);
      chan_pair_t it;
      it.a = a;
      it.b = b;
      pending_meas.push_back(it);
   endtask

   // Returns once every request has been sent and answered and the block has settled.
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_meas.size() != 0 || req_bus.valid || expected_drives.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Back-to-back writes keep valid high; csr_release lowers it afterwards.
   task automatic write_reg(input addr_type idx, input logic [DATA_W-1:0] val);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock);
      while (csr_bus.ready !== 1'b1);
   endtask

   task automatic csr_release();
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic load_settings(input logic [DATA_W-1:0] tgt, input logic [DATA_W-1:0] gp,
                                input logic [DATA_W-1:0] gi, input logic [DATA_W-1:0] gd,
                                input logic [DATA_W-1:0] hp, input logic [DATA_W-1:0] ip,
                                input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
      write_reg(REG_TARGET, tgt);
      write_reg(REG_GAIN_P, gp);
      write_reg(REG_GAIN_I, gi);
      write_reg(REG_GAIN_D, gd);
      write_reg(REG_HALF_PER, hp);
      write_reg(REG_INV_PER, ip);
      write_reg(REG_OUT_MIN, lo);
      write_reg(REG_OUT_MAX, hi);
   endtask

   initial begin
      int          tgt, off;
      bit          near;
      logic [31:0] gp, gi, gd, hp, ip, lo, hi;
      data_type    ma, mb;

      req_bus.valid      = 1'b0;
      req_bus.measured_a = '0;
      req_bus.measured_b = '0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = '0;
      csr_bus.data       = '0;

      set_point = TARGET_RST;
      kp        = GAIN_P_RST;
      ki        = GAIN_I_RST;
      kd        = GAIN_D_RST;
      half_per  = HALF_PER_RST;
      inv_per   = INV_PER_RST;
      lim_lo    = OUT_MIN_RST;
      lim_hi    = OUT_MAX_RST;
      foreach (err_hist[c]) begin
         err_hist[c] = 0;
         accum[c]    = 0;
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Settings left at their reset values; error saturation at the extremes.
      queue_item(0, 0);
      queue_item(DATA_MAX, DATA_MIN);
      queue_item(DATA_MIN, DATA_MAX);
      queue_item(-1, 1);
      queue_item(6553600, -6553600);
      wait_idle();

      // Largest gains and periods: products, the integral and the sum all saturate.
      // The half period is written with its unused top bit set.
      load_settings(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MIN,
                    32'hFFFF_FFFF, 32'h7FFF_FFFF, DATA_MIN, DATA_MAX);
      csr_release();
      repeat (3) queue_item(DATA_MIN, DATA_MIN);
      repeat (3) queue_item(DATA_MAX, DATA_MAX);
      queue_item(0, -1);
      wait_idle();

      // Crossed limits, and writes to indexes beyond the register file.
      load_settings(32'(1 << 16), 32'(1 << 16), 0, 0, 32768, 65536,
                    32'(1000 << 16), -32'(1000 << 16));
      write_reg(addr_type'(REG_OUT_MAX + 1), 32'h5A5A_A5A5);
      write_reg(ADDR_TOP, 32'hFFFF_FFFF);
      csr_release();
      queue_item(0, 32'(2000 << 16));
      queue_item(-32'(2000 << 16), DATA_MIN);
      queue_item(32'(1 << 16), DATA_MAX);
      queue_item(-1, 32'(500 << 16));
      wait_idle();

      // Most negative setpoint and proportional gain with both periods at zero.
      load_settings(DATA_MIN, DATA_MIN, 32'h0000_8000, DATA_MAX, 0, 0,
                    -32'(50 << 16), 32'(50 << 16));
      csr_release();
      queue_item(DATA_MAX, 0);
      queue_item(DATA_MIN, DATA_MAX);
      queue_item(0, 0);
      queue_item(1, -1);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         near = (p % 2 == 0);
         no_idle = (p % 3 == 1);
         if (near) begin
            tgt = $urandom_range(0, 100 << 16);
            gp  = $urandom_range(0, 1 << 19);
            gi  = $urandom_range(0, 1 << 17);
            gd  = $urandom_range(0, 1 << 17);
            if ($urandom_range(0, 3) == 0) gp = -gp;
            if ($urandom_range(0, 3) == 0) gi = -gi;
            if ($urandom_range(0, 3) == 0) gd = -gd;
            hp  = $urandom_range(0, 1 << 17);
            ip  = $urandom_range(0, 1 << 20);
            lo  = -$urandom_range(0, 1 << 22);
            hi  = $urandom_range(0, 1 << 23);
         end else begin
            tgt = $urandom();
            gp  = $urandom();
            gi  = $urandom();
            gd  = $urandom();
            hp  = $urandom();
            ip  = $urandom();
            lo  = $urandom();
            hi  = $urandom();
         end
         load_settings(tgt, gp, gi, gd, hp, ip, lo, hi);
         if (p == 5) write_reg(addr_type'($urandom_range(REG_OUT_MAX + 1, ADDR_TOP)), $urandom());
         csr_release();

         if (p == 2) begin
            no_idle = 1'b1;
            start_long_hold = 1'b1;
         end

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // The sender waits for every outstanding result halfway through a phase.
            if (k == PHASE_ITEMS / 2) wait_idle();
            if ($urandom_range(0, 7) != 0) begin
               off = int'($urandom_range(0, 1 << 23)) - (1 << 22);
               ma = tgt + off;
               off = int'($urandom_range(0, 1 << 23)) - (1 << 22);
               mb = tgt + off;
            end else begin
               ma = $urandom();
               mb = $urandom();
            end
            if (!near && $urandom_range(0, 1) == 0) begin
               ma = $urandom();
               mb = $urandom();
            end
            queue_item(ma, mb);
         end
         wait_idle();
      end

      if (expected_drives.size() != 0) begin
         $error("%0d results never arrived", expected_drives.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("PASS dual_pid_controller_clamped_core");
      end else begin
         $display("FAIL dual_pid_controller_clamped_core");
      end
      $finish;
   end

endmodule
